// ===== rtl/pocc_pkg.sv =====
// ----------------------------------------------------------------------------
// pocc_pkg
// Shared widths, codes and word types of the occasion collision checker.
// ----------------------------------------------------------------------------
package pocc_pkg;

    localparam int OP_W     = 2;
    localparam int SYM_W    = 4;
    localparam int ROW_W    = 12;
    localparam int PERIOD_W = 14;
    localparam int OFFSET_W = 16;
    localparam int START_W  = 9;
    localparam int STOP_W   = 10;
    localparam int KIND_W   = 2;
    localparam int TAG_W    = 8;
    localparam int STATUS_W = 2;
    localparam int HIT_W    = 6;
    localparam int SLOT_W   = 27;

    localparam int DEF_MAX_ENTRIES = 64;
    localparam int DEF_SYMBOLS     = 14;
    localparam int DEF_SUBCARRIERS = 12;
    localparam int DEF_MAX_PERIOD  = 10240;

    localparam logic [OP_W-1:0] OPC_STAGE = 2'd0;
    localparam logic [OP_W-1:0] OPC_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OPC_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OPC_RSVD  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_HIT  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef enum logic [1:0] {
        CMD_STAGE,
        CMD_ADD,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [SYM_W-1:0]    symbol_index;
        logic [ROW_W-1:0]    element_row;
        logic [PERIOD_W-1:0] period;
        logic [OFFSET_W-1:0] offset;
        logic [START_W-1:0]  block_start;
        logic [STOP_W-1:0]   block_stop;
        logic [KIND_W-1:0]   source_kind;
        logic [TAG_W-1:0]    primary_tag;
        logic [TAG_W-1:0]    secondary_tag;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HIT_W-1:0]    hit_index;
        logic [KIND_W-1:0]   hit_kind;
        logic [TAG_W-1:0]    hit_primary;
        logic [TAG_W-1:0]    hit_secondary;
        logic [SLOT_W-1:0]   first_slot;
        logic [SLOT_W-1:0]   joint_period;
    } result_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [SYM_W-1:0]    sym;
        logic [ROW_W-1:0]    row;
        logic [PERIOD_W-1:0] period;
        logic [OFFSET_W-1:0] offset;
        logic [START_W-1:0]  start;
        logic [STOP_W-1:0]   stop;
        logic [KIND_W-1:0]   src_kind;
        logic [TAG_W-1:0]    primary;
        logic [TAG_W-1:0]    secondary;
    } cmd_t;

endpackage

// ===== rtl/pocc_front.sv =====
// ----------------------------------------------------------------------------
// pocc_front
// Accepts input words, decodes the operation, clamps the period and queues
// commands for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module pocc_front #(
    parameter int MAX_PERIOD = pocc_pkg::DEF_MAX_PERIOD
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  pocc_pkg::item_t item,
    output logic            cmd_valid,
    input  logic            cmd_pop,
    output pocc_pkg::cmd_t  cmd
);
    import pocc_pkg::*;

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    cmd_t       dec;
    logic       known;
    logic       wr_en;
    logic       rd_en;

    always_comb
    begin
        dec           = '0;
        known         = 1'b1;
        dec.sym       = item.symbol_index;
        dec.row       = item.element_row;
        dec.offset    = item.offset;
        dec.start     = item.block_start;
        dec.stop      = item.block_stop;
        dec.src_kind  = item.source_kind;
        dec.primary   = item.primary_tag;
        dec.secondary = item.secondary_tag;
        if (item.period == '0)
            dec.period = PERIOD_W'(1);
        else if (int'(item.period) > MAX_PERIOD)
            dec.period = PERIOD_W'(MAX_PERIOD);
        else
            dec.period = item.period;
        case (item.operation)
            OPC_STAGE: dec.kind = CMD_STAGE;
            OPC_ADD:   dec.kind = CMD_ADD;
            OPC_CLEAR: dec.kind = CMD_CLEAR;
            default:
            begin
                dec.kind = CMD_STAGE;
                known    = 1'b0;
            end
        endcase
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = fifo_reg[rd_ptr_reg];
    assign wr_en     = push && !full && known;
    assign rd_en     = cmd_pop && cmd_valid;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            fifo_reg[wr_ptr_reg] <= dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= !wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= !rd_ptr_reg;
            if (wr_en && !rd_en)
                cnt_reg <= cnt_reg + 2'd1;
            else if (rd_en && !wr_en)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

// ===== rtl/pocc_div.sv =====
// ----------------------------------------------------------------------------
// pocc_div
// Restoring divider, one quotient bit per cycle; divisor must be nonzero.
// ----------------------------------------------------------------------------
module pocc_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [pocc_pkg::OFFSET_W-1:0]    dividend,
    input  logic [pocc_pkg::PERIOD_W-1:0]    divisor,
    output logic                             done,
    output logic [pocc_pkg::OFFSET_W-1:0]    quotient,
    output logic [pocc_pkg::PERIOD_W-1:0]    remainder
);
    import pocc_pkg::*;

    localparam int CNT_W = $clog2(OFFSET_W);

    logic [OFFSET_W-1:0] quo_reg;
    logic [PERIOD_W-1:0] rem_reg;
    logic [PERIOD_W-1:0] dvs_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [PERIOD_W:0]   shifted;
    logic [PERIOD_W:0]   trial;

    assign shifted   = {rem_reg, quo_reg[OFFSET_W-1]};
    assign trial     = shifted - {1'b0, dvs_reg};
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[PERIOD_W])
            begin
                rem_reg <= trial[PERIOD_W-1:0];
                quo_reg <= {quo_reg[OFFSET_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[PERIOD_W-1:0];
                quo_reg <= {quo_reg[OFFSET_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(OFFSET_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/pocc_gcd.sv =====
// ----------------------------------------------------------------------------
// pocc_gcd
// Binary gcd of two nonzero periods, one reduction step per cycle.
// ----------------------------------------------------------------------------
module pocc_gcd (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pocc_pkg::PERIOD_W-1:0] a,
    input  logic [pocc_pkg::PERIOD_W-1:0] b,
    output logic                          done,
    output logic [pocc_pkg::PERIOD_W-1:0] g
);
    import pocc_pkg::*;

    localparam int K_W = $clog2(PERIOD_W);

    logic [PERIOD_W-1:0] a_reg;
    logic [PERIOD_W-1:0] b_reg;
    logic [PERIOD_W-1:0] g_reg;
    logic [K_W-1:0]      k_reg;
    logic                busy_reg;
    logic                done_reg;

    assign done = done_reg;
    assign g    = g_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
            k_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (a_reg == b_reg)
                g_reg <= a_reg << k_reg;
            else if (!a_reg[0] && !b_reg[0])
            begin
                a_reg <= a_reg >> 1;
                b_reg <= b_reg >> 1;
                k_reg <= k_reg + K_W'(1);
            end
            else if (!a_reg[0])
                a_reg <= a_reg >> 1;
            else if (!b_reg[0])
                b_reg <= b_reg >> 1;
            else if (a_reg > b_reg)
                a_reg <= (a_reg - b_reg) >> 1;
            else
                b_reg <= (b_reg - a_reg) >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && (a_reg == b_reg))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

endmodule

// ===== rtl/pocc_engine.sv =====
// ----------------------------------------------------------------------------
// pocc_engine
// Back end: staging rows, occasion table, per-entry collision walk, slot
// solution search and the result register.
// ----------------------------------------------------------------------------
module pocc_engine #(
    parameter int MAX_ENTRIES           = pocc_pkg::DEF_MAX_ENTRIES,
    parameter int SYMBOLS_PER_SLOT      = pocc_pkg::DEF_SYMBOLS,
    parameter int SUBCARRIERS_PER_BLOCK = pocc_pkg::DEF_SUBCARRIERS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_pop,
    input  pocc_pkg::cmd_t     cmd,
    output logic               empty,
    input  logic               pop,
    output pocc_pkg::result_t  result
);
    import pocc_pkg::*;

    localparam int CW        = $clog2(MAX_ENTRIES + 1);
    localparam int IW        = $clog2(MAX_ENTRIES);
    localparam int SW        = (SYMBOLS_PER_SLOT > 1) ? $clog2(SYMBOLS_PER_SLOT) : 1;
    localparam int SUB       = SUBCARRIERS_PER_BLOCK;
    localparam int ROW_DEPTH = MAX_ENTRIES * (1 << SW);

    typedef enum logic [3:0] {
        S_IDLE, S_OFS_W, S_NEXT, S_RD, S_ROW_A, S_ROW_B, S_GCD_W, S_DIFF_W,
        S_STEP_W, S_LCM, S_RA_W, S_PBM_W, S_CRT, S_STORE, S_COPY, S_RESP
    } state_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] offset;
        logic [START_W-1:0]  start;
        logic [STOP_W-1:0]   stop;
        logic [KIND_W-1:0]   src_kind;
        logic [TAG_W-1:0]    primary;
        logic [TAG_W-1:0]    secondary;
    } ent_t;

    state_t              state_reg,  state_next;
    logic [CW-1:0]       cnt_reg,    cnt_next;
    logic [CW-1:0]       idx_reg,    idx_next;
    logic [SW-1:0]       sym_reg,    sym_next;
    cmd_t                cur_reg,    cur_next;
    logic [PERIOD_W-1:0] ob_reg,     ob_next;
    logic [PERIOD_W-1:0] g_reg,      g_next;
    logic [PERIOD_W-1:0] steps_reg,  steps_next;
    logic [SLOT_W-1:0]   lcm_reg,    lcm_next;
    logic [PERIOD_W-1:0] r_reg,      r_next;
    logic [PERIOD_W-1:0] pbm_reg,    pbm_next;
    logic [SLOT_W-1:0]   x_reg,      x_next;
    logic [PERIOD_W-1:0] k_reg,      k_next;
    result_t             res_reg,    res_next;
    result_t             out_reg,    out_next;
    logic                outv_reg,   outv_next;
    logic [SUB-1:0]      stage_reg  [SYMBOLS_PER_SLOT];
    logic [SUB-1:0]      stage_next [SYMBOLS_PER_SLOT];

    ent_t                ent_mem [MAX_ENTRIES];
    ent_t                ent_q;
    ent_t                ent_wr;
    logic                ent_we;
    logic [SUB-1:0]      row_mem [ROW_DEPTH];
    logic [SUB-1:0]      row_q;
    logic                row_we;
    logic [IW+SW-1:0]    row_rd_addr;
    logic [IW+SW-1:0]    row_wr_addr;

    logic                  div_start;
    logic [OFFSET_W-1:0]   div_a;
    logic [PERIOD_W-1:0]   div_b;
    logic                  div_done;
    logic [OFFSET_W-1:0]   div_q;
    logic [PERIOD_W-1:0]   div_r;
    logic                  gcd_start;
    logic                  gcd_done;
    logic [PERIOD_W-1:0]   gcd_g;

    logic [PERIOD_W-1:0]   diff;
    logic [2*PERIOD_W-1:0] prod;
    logic [PERIOD_W:0]     r_sum;
    logic                  overlap;

    pocc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    pocc_gcd u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .a     (ent_q.period),
        .b     (cur_reg.period),
        .done  (gcd_done),
        .g     (gcd_g)
    );

    assign diff        = (ent_q.offset >= ob_reg) ? (ent_q.offset - ob_reg)
                                                  : (ob_reg - ent_q.offset);
    assign prod        = steps_reg * cur_reg.period;
    assign r_sum       = {1'b0, r_reg} + {1'b0, pbm_reg};
    assign overlap     = ({1'b0, ent_q.start} < cur_reg.stop)
                      && ({1'b0, cur_reg.start} < ent_q.stop);
    assign row_rd_addr = {idx_reg[IW-1:0], sym_reg};
    assign row_wr_addr = {cnt_reg[IW-1:0], sym_reg};
    assign empty       = !outv_reg;
    assign result      = out_reg;

    always_comb
    begin
        ent_wr.period    = cur_reg.period;
        ent_wr.offset    = ob_reg;
        ent_wr.start     = cur_reg.start;
        ent_wr.stop      = cur_reg.stop;
        ent_wr.src_kind  = cur_reg.src_kind;
        ent_wr.primary   = cur_reg.primary;
        ent_wr.secondary = cur_reg.secondary;
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[cnt_reg[IW-1:0]] <= ent_wr;
        ent_q <= ent_mem[idx_reg[IW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
            row_mem[row_wr_addr] <= stage_reg[sym_reg];
        row_q <= row_mem[row_rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        sym_next   = sym_reg;
        cur_next   = cur_reg;
        ob_next    = ob_reg;
        g_next     = g_reg;
        steps_next = steps_reg;
        lcm_next   = lcm_reg;
        r_next     = r_reg;
        pbm_next   = pbm_reg;
        x_next     = x_reg;
        k_next     = k_reg;
        res_next   = res_reg;
        out_next   = out_reg;
        outv_next  = outv_reg;
        stage_next = stage_reg;
        cmd_pop    = 1'b0;
        ent_we     = 1'b0;
        row_we     = 1'b0;
        div_start  = 1'b0;
        div_a      = cur_reg.offset;
        div_b      = cur_reg.period;
        gcd_start  = 1'b0;

        if (pop && outv_reg)
            outv_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        CMD_STAGE:
                        begin
                            if (int'(cmd.sym) < SYMBOLS_PER_SLOT)
                                stage_next[cmd.sym[SW-1:0]] = cmd.row[SUB-1:0];
                        end
                        CMD_CLEAR:
                            cnt_next = '0;
                        CMD_ADD:
                        begin
                            cur_next = cmd;
                            res_next = '0;
                            if (cnt_reg == CW'(MAX_ENTRIES))
                            begin
                                res_next.status = STATUS_FULL;
                                for (int s = 0; s < SYMBOLS_PER_SLOT; s++)
                                    stage_next[s] = '0;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                div_a      = cmd.offset;
                                div_b      = cmd.period;
                                state_next = S_OFS_W;
                            end
                        end
                        default:
                            cnt_next = cnt_reg;
                    endcase
                end
            end
            S_OFS_W:
            begin
                if (div_done)
                begin
                    ob_next    = div_r;
                    idx_next   = '0;
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                sym_next = '0;
                if (idx_reg == cnt_reg)
                    state_next = S_STORE;
                else
                    state_next = S_RD;
            end
            S_RD:
            begin
                if (overlap)
                    state_next = S_ROW_A;
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_NEXT;
                end
            end
            S_ROW_A:
                state_next = S_ROW_B;
            S_ROW_B:
            begin
                if ((row_q & stage_reg[sym_reg]) != '0)
                begin
                    gcd_start  = 1'b1;
                    state_next = S_GCD_W;
                end
                else if (sym_reg == SW'(SYMBOLS_PER_SLOT - 1))
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_NEXT;
                end
                else
                begin
                    sym_next   = sym_reg + SW'(1);
                    state_next = S_ROW_A;
                end
            end
            S_GCD_W:
            begin
                if (gcd_done)
                begin
                    g_next     = gcd_g;
                    div_start  = 1'b1;
                    div_a      = OFFSET_W'(diff);
                    div_b      = gcd_g;
                    state_next = S_DIFF_W;
                end
            end
            S_DIFF_W:
            begin
                if (div_done)
                begin
                    if (div_r != '0)
                    begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        div_a      = OFFSET_W'(ent_q.period);
                        div_b      = g_reg;
                        state_next = S_STEP_W;
                    end
                end
            end
            S_STEP_W:
            begin
                if (div_done)
                begin
                    steps_next = div_q[PERIOD_W-1:0];
                    state_next = S_LCM;
                end
            end
            S_LCM:
            begin
                lcm_next   = prod[SLOT_W-1:0];
                div_start  = 1'b1;
                div_a      = OFFSET_W'(ob_reg);
                div_b      = ent_q.period;
                state_next = S_RA_W;
            end
            S_RA_W:
            begin
                if (div_done)
                begin
                    r_next     = div_r;
                    div_start  = 1'b1;
                    div_a      = OFFSET_W'(cur_reg.period);
                    div_b      = ent_q.period;
                    state_next = S_PBM_W;
                end
            end
            S_PBM_W:
            begin
                if (div_done)
                begin
                    pbm_next   = div_r;
                    x_next     = SLOT_W'(ob_reg);
                    k_next     = '0;
                    state_next = S_CRT;
                end
            end
            S_CRT:
            begin
                if ((r_reg == ent_q.offset) || (k_reg == steps_reg))
                begin
                    res_next.status        = STATUS_HIT;
                    res_next.hit_index     = HIT_W'(idx_reg);
                    res_next.hit_kind      = ent_q.src_kind;
                    res_next.hit_primary   = ent_q.primary;
                    res_next.hit_secondary = ent_q.secondary;
                    res_next.first_slot    = (x_reg >= lcm_reg) ? '0 : x_reg;
                    res_next.joint_period  = lcm_reg;
                    sym_next               = '0;
                    state_next             = S_STORE;
                end
                else
                begin
                    x_next = x_reg + SLOT_W'(cur_reg.period);
                    if (r_sum >= {1'b0, ent_q.period})
                        r_next = PERIOD_W'(r_sum - {1'b0, ent_q.period});
                    else
                        r_next = r_sum[PERIOD_W-1:0];
                    k_next = k_reg + PERIOD_W'(1);
                end
            end
            S_STORE:
            begin
                ent_we     = 1'b1;
                sym_next   = '0;
                state_next = S_COPY;
            end
            S_COPY:
            begin
                row_we = 1'b1;
                if (sym_reg == SW'(SYMBOLS_PER_SLOT - 1))
                begin
                    for (int s = 0; s < SYMBOLS_PER_SLOT; s++)
                        stage_next[s] = '0;
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = S_RESP;
                end
                else
                    sym_next = sym_reg + SW'(1);
            end
            S_RESP:
            begin
                if (!outv_reg || pop)
                begin
                    out_next   = res_reg;
                    outv_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        ob_reg    <= ob_next;
        g_reg     <= g_next;
        steps_reg <= steps_next;
        lcm_reg   <= lcm_next;
        r_reg     <= r_next;
        pbm_reg   <= pbm_next;
        x_reg     <= x_next;
        k_reg     <= k_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
        sym_reg   <= sym_next;
        idx_reg   <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            outv_reg  <= 1'b0;
            for (int s = 0; s < SYMBOLS_PER_SLOT; s++)
                stage_reg[s] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            outv_reg  <= outv_next;
            stage_reg <= stage_next;
        end
    end

endmodule

// ===== rtl/periodic_occasion_collision_check.sv =====
// ----------------------------------------------------------------------------
// periodic_occasion_collision_check
// Table of periodic resource occasions with collision check on every add.
// ----------------------------------------------------------------------------
// Input channel: push/full with one item word. Operation stage writes one
// symbol row of the staging mask, clear empties the table, add checks the
// staged occasion against stored entries up to the first hit and stores it.
// Result channel: empty/pop; one result word per add, none for other words.
// A two-word queue sits in front; one command is worked at a time.
// When the table is full an add stores nothing. Otherwise it reduces the
// offset with the divider and walks the stored entries, scanning mask rows
// where the blocks overlap; for a pair that matches in blocks and mask it
// runs gcd and divider steps, and the first collision adds a slot search over
// candidate slots one period apart. Storing writes the entry, then copies each
// staging row. The divider is shared and the slot search steps once per cycle.
// Reset empties the queue, the table and the staging rows.
// A result that is not popped holds the back end; the front queue then fills
// and full rises.
// ----------------------------------------------------------------------------
module periodic_occasion_collision_check #(
    parameter int MAX_ENTRIES           = pocc_pkg::DEF_MAX_ENTRIES,
    parameter int SYMBOLS_PER_SLOT      = pocc_pkg::DEF_SYMBOLS,
    parameter int SUBCARRIERS_PER_BLOCK = pocc_pkg::DEF_SUBCARRIERS,
    parameter int MAX_PERIOD            = pocc_pkg::DEF_MAX_PERIOD
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  pocc_pkg::item_t   item,
    output logic              empty,
    input  logic              pop,
    output pocc_pkg::result_t result
);
    import pocc_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;

    pocc_front #(
        .MAX_PERIOD (MAX_PERIOD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    pocc_engine #(
        .MAX_ENTRIES           (MAX_ENTRIES),
        .SYMBOLS_PER_SLOT      (SYMBOLS_PER_SLOT),
        .SUBCARRIERS_PER_BLOCK (SUBCARRIERS_PER_BLOCK)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ===== rtl/pocc_check.sv =====
// ----------------------------------------------------------------------------
// pocc_check
// Port-level checks on the result channel of the collision checker.
// ----------------------------------------------------------------------------
module pocc_check (
    input logic              clk,
    input logic              rst_n,
    input logic              empty,
    input logic              pop,
    input pocc_pkg::result_t result
);
    import pocc_pkg::*;

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.status == STATUS_NONE || result.status == STATUS_HIT
                    || result.status == STATUS_FULL))
        else $error("bad status code");

    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status != STATUS_HIT) |->
            (result.joint_period == '0 && result.first_slot == '0
             && result.hit_index == '0))
        else $error("fields set without collision");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status == STATUS_HIT) |->
            (result.joint_period != '0 && result.first_slot < result.joint_period))
        else $error("first slot not below joint period");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result word changed while stalled");

endmodule

bind periodic_occasion_collision_check pocc_check u_pocc_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

// ===== tb/sv/periodic_occasion_collision_check_checker.sv =====
// ----------------------------------------------------------------------------
// periodic_occasion_collision_check_checker
// Watches the item and result channels of the occasion collision checker,
// keeps its own occasion table, computes the expected word for every add and
// compares each popped result word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_occasion_collision_check_checker
    import pocc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  logic    full,
    input  item_t   item,
    input  logic    empty,
    input  logic    pop,
    input  result_t result,
    output int      fail_count,
    output int      pending
);

    localparam int ENTRIES = DEF_MAX_ENTRIES;
    localparam int SYMS    = DEF_SYMBOLS;

    int unsigned occ_count;
    int unsigned occ_period [ENTRIES];
    int unsigned occ_offset [ENTRIES];
    int unsigned occ_start  [ENTRIES];
    int unsigned occ_stop   [ENTRIES];
    logic [1:0]  occ_kind   [ENTRIES];
    logic [7:0]  occ_pri    [ENTRIES];
    logic [7:0]  occ_sec    [ENTRIES];
    logic [ROW_W-1:0] occ_rows [ENTRIES][SYMS];
    logic [ROW_W-1:0] staged_rows [SYMS];
    result_t expected_words [$];

    function automatic int unsigned gcd_of(int unsigned a, int unsigned b);
        int unsigned t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    task automatic apply_item(input item_t it);
        result_t     w;
        int unsigned pb, ob, pa, oa, g, diff, steps, lcm, x, k;
        bit          hit;
        begin
            w = '0;
            if (it.operation == OPC_STAGE)
            begin
                if (it.symbol_index < SYMS)
                    staged_rows[it.symbol_index] = it.element_row;
            end
            else if (it.operation == OPC_CLEAR)
                occ_count = 0;
            else if (it.operation == OPC_ADD)
            begin
                if (occ_count >= ENTRIES)
                    w.status = STATUS_FULL;
                else
                begin
                    pb = it.period;
                    if (pb == 0) pb = 1;
                    if (pb > DEF_MAX_PERIOD) pb = DEF_MAX_PERIOD;
                    ob = it.offset % pb;
                    for (int i = 0; i < occ_count; i++)
                    begin
                        pa = occ_period[i];
                        oa = occ_offset[i];
                        g = gcd_of(pa, pb);
                        diff = (oa >= ob) ? oa - ob : ob - oa;
                        if (diff % g != 0) continue;
                        if (!(occ_start[i] < it.block_stop && it.block_start < occ_stop[i]))
                            continue;
                        hit = 0;
                        for (int s = 0; s < SYMS; s++)
                            if ((occ_rows[i][s] & staged_rows[s]) != 0) hit = 1;
                        if (!hit) continue;
                        steps = pa / g;
                        lcm = steps * pb;
                        x = ob;
                        for (k = 0; k < steps && (x % pa) != oa; k++)
                            x += pb;
                        if (x >= lcm) x = 0;
                        w.status        = STATUS_HIT;
                        w.hit_index     = HIT_W'(i);
                        w.hit_kind      = occ_kind[i];
                        w.hit_primary   = occ_pri[i];
                        w.hit_secondary = occ_sec[i];
                        w.first_slot    = SLOT_W'(x);
                        w.joint_period  = SLOT_W'(lcm);
                        break;
                    end
                    occ_period[occ_count] = pb;
                    occ_offset[occ_count] = ob;
                    occ_start[occ_count]  = it.block_start;
                    occ_stop[occ_count]   = it.block_stop;
                    occ_kind[occ_count]   = it.source_kind;
                    occ_pri[occ_count]    = it.primary_tag;
                    occ_sec[occ_count]    = it.secondary_tag;
                    for (int s = 0; s < SYMS; s++)
                        occ_rows[occ_count][s] = staged_rows[s];
                    occ_count++;
                end
                for (int s = 0; s < SYMS; s++)
                    staged_rows[s] = '0;
                expected_words = {expected_words, w};
            end
        end
    endtask

    task automatic compare_word(input result_t got);
        result_t e;
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, got);
                fail_count++;
            end
            else
            begin
                e = expected_words.pop_front();
                if (got.status !== e.status || got.hit_index !== e.hit_index
                    || got.hit_kind !== e.hit_kind || got.hit_primary !== e.hit_primary
                    || got.hit_secondary !== e.hit_secondary
                    || got.first_slot !== e.first_slot
                    || got.joint_period !== e.joint_period)
                begin
                    $display("%0t: mismatch expected st=%0d idx=%0d k=%0d p=%0d s=%0d slot=%0d lcm=%0d",
                        $time, e.status, e.hit_index, e.hit_kind, e.hit_primary,
                        e.hit_secondary, e.first_slot, e.joint_period);
                    $display("%0t:          actual   st=%0d idx=%0d k=%0d p=%0d s=%0d slot=%0d lcm=%0d",
                        $time, got.status, got.hit_index, got.hit_kind, got.hit_primary,
                        got.hit_secondary, got.first_slot, got.joint_period);
                    fail_count++;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count = 0;
            occ_count  = 0;
            for (int s = 0; s < SYMS; s++)
                staged_rows[s] = '0;
            expected_words.delete();
            pending = 0;
        end
        else
        begin
            if (push && !full)
                apply_item(item);
            if (pop && !empty)
                compare_word(result);
            pending = expected_words.size();
        end
    end

endmodule

// ===== tb/sv/periodic_occasion_collision_check_tb.sv =====
// ----------------------------------------------------------------------------
// periodic_occasion_collision_check_tb
// Drives directed and random stage, add and clear words into the occasion
// collision checker with random idle bursts on both channels; the checker
// module predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_occasion_collision_check_tb;
    import pocc_pkg::*;

    localparam int CYCLE_LIMIT = 30000000;
    localparam int ITEM_W      = $bits(item_t);

    logic    clk;
    logic    rst_n;
    logic    push;
    logic    full;
    item_t   item;
    logic    empty;
    logic    pop;
    result_t result;
    int      fail_count;
    int      pending;
    int      cycles;
    bit      calm;

    periodic_occasion_collision_check dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result)
    );

    periodic_occasion_collision_check_checker checker_i (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL periodic_occasion_collision_check");
            $finish;
        end
    end

    // receiver: bursts of stall, none in the calm tail
    initial
    begin
        int n;
        pop = 0;
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 16);
                pop <= 0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                pop <= 1;
                @(posedge clk);
            end
        end
    end

    // push stays high between back-to-back words; full is stable at negedge
    task automatic send(input item_t w);
        int n;
        begin
            if (!calm && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 16);
                push <= 0;
                repeat (n) @(posedge clk);
            end
            item <= w;
            push <= 1;
            @(negedge clk);
            while (full) @(negedge clk);
            @(posedge clk);
        end
    endtask

    function automatic item_t mk_stage(input int sym, input int row);
        item_t w;
        w = item_t'(ITEM_W'({$urandom, $urandom, $urandom}));
        w.operation = OPC_STAGE;
        w.symbol_index = SYM_W'(sym);
        w.element_row = ROW_W'(row);
        return w;
    endfunction

    function automatic item_t mk_add(input int p, input int o, input int a, input int b);
        item_t w;
        w = item_t'(ITEM_W'({$urandom, $urandom, $urandom}));
        w.operation = OPC_ADD;
        w.period = PERIOD_W'(p);
        w.offset = OFFSET_W'(o);
        w.block_start = START_W'(a);
        w.block_stop = STOP_W'(b);
        return w;
    endfunction

    function automatic item_t rnd_add();
        int p;
        case ($urandom_range(0, 5))
            0: p = $urandom_range(0, 16383);
            1: p = 10240;
            default: p = $urandom_range(1, 40);
        endcase
        return mk_add(p, $urandom_range(0, 65535), $urandom_range(0, 40),
            ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(20, 60));
    endfunction

    task automatic wait_drain();
        begin
            push <= 0;
            @(posedge clk);
            while (pending != 0) @(posedge clk);
            repeat (300) @(posedge clk);
        end
    endtask

    initial
    begin
        item_t w;
        int    sent;
        bit    drained;
        push   = 0;
        item   = '0;
        calm   = 0;
        cycles = 0;
        rst_n  = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, reversed interval, ignored words, full table
        send(mk_stage(0, 12'hfff));
        send(mk_stage(13, 12'h001));
        send(mk_stage(14, 12'hfff));
        send(mk_add(0, 65535, 0, 512));
        send(mk_stage(0, 12'h800));
        send(mk_add(16383, 12345, 511, 512));
        send(mk_stage(0, 12'h800));
        send(mk_add(10240, 0, 0, 1));
        send(mk_stage(13, 12'h001));
        send(mk_add(6, 4, 10, 5));
        w = mk_stage(0, 12'hfff);
        w.operation = OPC_RSVD;
        send(w);
        send(mk_stage(0, 12'h001));
        send(mk_add(4, 2, 0, 100));
        send(mk_stage(0, 12'h001));
        send(mk_add(6, 5, 50, 60));
        w = item_t'('0);
        w.operation = OPC_CLEAR;
        send(w);
        wait_drain();
        for (int i = 0; i < 66; i++)
            send(mk_add($urandom_range(1, 10240), $urandom, 0, 0));
        send(w);

        // random: mostly stage runs followed by an add
        sent    = 0;
        drained = 0;
        while (sent < 205)
        begin
            if (sent > 170) calm = 1;
            if (!drained && sent >= 100)
            begin
                drained = 1;
                wait_drain();
            end
            case ($urandom_range(0, 19))
                0: send(w);
                1: send(item_t'(ITEM_W'({$urandom, $urandom, $urandom})));
                default:
                begin
                    repeat ($urandom_range(0, 3))
                    begin
                        send(mk_stage($urandom_range(0, 15), $urandom_range(0, 4095)));
                        sent++;
                    end
                    send(rnd_add());
                end
            endcase
            sent++;
        end

        wait_drain();
        if (fail_count == 0)
            $display("PASS periodic_occasion_collision_check");
        else
            $display("FAIL periodic_occasion_collision_check");
        $finish;
    end

endmodule
